// ----- hdl/tun_pkg.sv -----
// Package: widths, stage payload types and step functions of the unit normal pipeline.
`default_nettype none

package tun_pkg;

    localparam int COORD_BITS = 16;
    localparam int DW         = COORD_BITS + 1;
    localparam int PW         = 2 * DW;
    localparam int CW         = PW + 1;
    localparam int MW         = CW;
    localparam int RW         = 30;
    localparam int SQW        = 2 * RW;
    localparam int SUMW       = SQW + 2;
    localparam int ROOTW      = SUMW / 2;
    localparam int REMW       = ROOTW + 2;
    localparam int FRACB      = 14;
    localparam int ONE_Q14    = 1 << FRACB;
    localparam int QW         = FRACB + 1;
    localparam int QBW        = $clog2(QW);
    localparam int NUMW       = RW + FRACB + 1;
    localparam int OUTW       = 16;
    localparam int SMAX       = MW - RW;
    localparam int SW         = $clog2(SMAX + 2);
    localparam int NPRE       = 7;
    localparam int NSQ        = ROOTW + 1;
    localparam int NDV        = QW + 1;
    localparam int NST        = NPRE + NSQ + NDV + 1;

    typedef struct packed {
        logic [SUMW-1:0]        x;
        logic [REMW-1:0]        rem;
        logic [ROOTW-1:0]       root;
        logic [2:0][RW-1:0]     mg;
        logic [2:0]             neg;
        logic                   degen;
    } sq_t;

    typedef struct packed {
        logic [2:0][NUMW-1:0]   rem;
        logic [2:0][QW-1:0]     q;
        logic [ROOTW-1:0]       len;
        logic [2:0]             neg;
        logic                   degen;
    } dv_t;

    function automatic sq_t sq_step(sq_t a);
        sq_t             o;
        logic [REMW-1:0] r2;
        logic [REMW-1:0] tr;
        o  = a;
        r2 = {a.rem[REMW-3:0], a.x[SUMW-1 -: 2]};
        tr = {a.root, 2'b01};
        o.x = a.x << 2;
        if (r2 >= tr) begin
            o.rem  = r2 - tr;
            o.root = {a.root[ROOTW-2:0], 1'b1};
        end else begin
            o.rem  = r2;
            o.root = {a.root[ROOTW-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic dv_t dv_step(dv_t a, logic [QBW-1:0] b);
        dv_t             o;
        logic [NUMW:0]   den;
        o   = a;
        den = {{(NUMW+1-ROOTW){1'b0}}, a.len} << b;
        for (int j = 0; j < 3; j++) begin
            if ({1'b0, a.rem[j]} >= den) begin
                o.rem[j]  = a.rem[j] - den[NUMW-1:0];
                o.q[j][b] = 1'b1;
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/triangle_unit_normal_unit.sv -----
// Top level: pipelined unit face normal of one triangle per cycle unless the output stalls.
//
//  channel | ports                          | payload
//  --------+--------------------------------+-----------------------------------------
//  in      | s_tvalid s_tready s_tdata[143:0] | ax ay az bx by_coord bz cx cy cz
//  out     | m_tvalid m_tready m_tdata[47:0]  | nx ny nz; m_tuser = degenerate
//
//  One item per cycle unless the output stalls; stages: differences, products,
//  cross, magnitude, max, range reduction, squares, sum, 31 square-root digit stages,
//  numerator setup, 15 quotient-bit stages and the output register.
//  All stages advance together whenever the output register is empty or taken.
//  aresetn clears the valid bits only.
`default_nettype none

module triangle_unit_normal_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz
    input  wire logic [9*tun_pkg::COORD_BITS-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // nx, ny, nz
    output logic [3*tun_pkg::OUTW-1:0]           m_tdata,
    // degenerate
    output logic                                 m_tuser
);

    localparam int CB = tun_pkg::COORD_BITS;
    localparam int DW = tun_pkg::DW;
    localparam int PW = tun_pkg::PW;
    localparam int CW = tun_pkg::CW;
    localparam int MW = tun_pkg::MW;
    localparam int RW = tun_pkg::RW;

    logic                          en;
    logic [tun_pkg::NST-1:0]       vld_reg;
    logic [tun_pkg::NST-1:0]       vld_next;

    logic signed [5:0][DW-1:0]     d_reg;
    logic signed [5:0][PW-1:0]     p_reg;
    logic signed [2:0][CW-1:0]     c_reg;
    logic [2:0][MW-1:0]            mg4_reg;
    logic [2:0]                    neg4_reg;
    logic [2:0][MW-1:0]            mg5_reg;
    logic [2:0]                    neg5_reg;
    logic [MW-1:0]                 m5_reg;
    logic [2:0][RW-1:0]            r6_reg;
    logic [2:0]                    neg6_reg;
    logic                          degen6_reg;
    logic [2:0][tun_pkg::SQW-1:0]  sqr7_reg;
    logic [2:0][RW-1:0]            r7_reg;
    logic [2:0]                    neg7_reg;
    logic                          degen7_reg;
    tun_pkg::sq_t                  sq_reg [tun_pkg::NSQ];
    tun_pkg::dv_t                  dv_reg [tun_pkg::NDV];
    logic [3*tun_pkg::OUTW-1:0]    out_reg;
    logic                          deg_reg;

    logic signed [CB-1:0]          crd [9];
    logic [2:0][MW-1:0]            mg_c;
    logic [MW-1:0]                 m_c;
    logic [tun_pkg::SW-1:0]        s_c;
    tun_pkg::sq_t                  sq0_c;
    tun_pkg::dv_t                  dv0_c;
    logic [3*tun_pkg::OUTW-1:0]    out_next;

    assign en       = ~vld_reg[tun_pkg::NST-1] | m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[tun_pkg::NST-2:0], s_tvalid};

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            crd[i] = s_tdata[i*CB +: CB];
        end
        for (int j = 0; j < 3; j++) begin
            mg_c[j] = c_reg[j][CW-1] ? MW'(-c_reg[j]) : MW'(c_reg[j]);
        end
        m_c = mg4_reg[0];
        if (mg4_reg[1] > m_c) begin
            m_c = mg4_reg[1];
        end
        if (mg4_reg[2] > m_c) begin
            m_c = mg4_reg[2];
        end
        s_c = '0;
        for (int t = 0; t <= tun_pkg::SMAX; t++) begin
            if ((m5_reg >> t) >= (MW'(1) << RW)) begin
                s_c = tun_pkg::SW'(t + 1);
            end
        end
        sq0_c.x     = tun_pkg::SUMW'(sqr7_reg[0]) + tun_pkg::SUMW'(sqr7_reg[1])
                    + tun_pkg::SUMW'(sqr7_reg[2]);
        sq0_c.rem   = '0;
        sq0_c.root  = '0;
        sq0_c.mg    = r7_reg;
        sq0_c.neg   = neg7_reg;
        sq0_c.degen = degen7_reg;
        dv0_c.len   = sq_reg[tun_pkg::NSQ-1].root;
        dv0_c.neg   = sq_reg[tun_pkg::NSQ-1].neg;
        dv0_c.degen = sq_reg[tun_pkg::NSQ-1].degen;
        dv0_c.q     = '0;
        for (int j = 0; j < 3; j++) begin
            dv0_c.rem[j] = {1'b0, sq_reg[tun_pkg::NSQ-1].mg[j], tun_pkg::FRACB'(0)}
                         + tun_pkg::NUMW'(sq_reg[tun_pkg::NSQ-1].root >> 1);
        end
    end

    always_comb begin
        logic [tun_pkg::OUTW-1:0] qm;
        for (int j = 0; j < 3; j++) begin
            qm = tun_pkg::OUTW'(dv_reg[tun_pkg::NDV-1].q[j]);
            if (qm > tun_pkg::OUTW'(tun_pkg::ONE_Q14)) begin
                qm = tun_pkg::OUTW'(tun_pkg::ONE_Q14);
            end
            if (dv_reg[tun_pkg::NDV-1].degen) begin
                qm = '0;
            end
            out_next[j*tun_pkg::OUTW +: tun_pkg::OUTW] =
                dv_reg[tun_pkg::NDV-1].neg[j] ? -qm : qm;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                d_reg[j]     <= DW'(crd[j]) - DW'(crd[3+j]);
                d_reg[3+j]   <= DW'(crd[3+j]) - DW'(crd[6+j]);
            end
            p_reg[0] <= $signed(d_reg[1]) * $signed(d_reg[5]);
            p_reg[1] <= $signed(d_reg[2]) * $signed(d_reg[4]);
            p_reg[2] <= $signed(d_reg[2]) * $signed(d_reg[3]);
            p_reg[3] <= $signed(d_reg[0]) * $signed(d_reg[5]);
            p_reg[4] <= $signed(d_reg[0]) * $signed(d_reg[4]);
            p_reg[5] <= $signed(d_reg[1]) * $signed(d_reg[3]);
            for (int j = 0; j < 3; j++) begin
                c_reg[j] <= CW'($signed(p_reg[2*j])) - CW'($signed(p_reg[2*j+1]));
                neg4_reg[j] <= c_reg[j][CW-1];
            end
            mg4_reg    <= mg_c;
            mg5_reg    <= mg4_reg;
            neg5_reg   <= neg4_reg;
            m5_reg     <= m_c;
            for (int j = 0; j < 3; j++) begin
                r6_reg[j]   <= RW'(mg5_reg[j] >> s_c);
                sqr7_reg[j] <= r6_reg[j] * r6_reg[j];
            end
            neg6_reg   <= neg5_reg;
            degen6_reg <= (m5_reg == '0);
            r7_reg     <= r6_reg;
            neg7_reg   <= neg6_reg;
            degen7_reg <= degen6_reg;
            sq_reg[0]  <= sq0_c;
            for (int k = 0; k < tun_pkg::NSQ - 1; k++) begin
                sq_reg[k+1] <= tun_pkg::sq_step(sq_reg[k]);
            end
            dv_reg[0]  <= dv0_c;
            for (int k = 0; k < tun_pkg::NDV - 1; k++) begin
                dv_reg[k+1] <= tun_pkg::dv_step(dv_reg[k],
                                                tun_pkg::QBW'(tun_pkg::QW - 1 - k));
            end
            out_reg    <= out_next;
            deg_reg    <= dv_reg[tun_pkg::NDV-1].degen;
        end
    end

    assign m_tvalid = vld_reg[tun_pkg::NST-1];
    assign m_tdata  = out_reg;
    assign m_tuser  = deg_reg;

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate item with nonzero normal");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled item changed");

    a_ready_en: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow pipeline advance");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[tun_pkg::NPRE + tun_pkg::NSQ - 1] && !sq_reg[tun_pkg::NSQ-1].degen
        |-> sq_reg[tun_pkg::NSQ-1].root != '0)
        else $error("zero length for nondegenerate item");
`endif

endmodule

`default_nettype wire
